### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define ALSF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("alsf assertion failed");

// Concurrent assertion that also covers the reset cycles.
`define ALSF_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("alsf assertion failed");

`endif

### design/alsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package alsf_pkg;

  localparam int unsigned MaxPointsDef = 256;
  localparam int unsigned QDepth = 2;
  localparam int unsigned BigW = 128;
  localparam int unsigned MemDepth = 19;
  localparam int unsigned PcW = 6;
  localparam int unsigned ScaleCoef = 16;
  localparam int unsigned ScaleOfs = 12;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_SINGULAR = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic               last_point;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] offset_x;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic signed [31:0] offset_y;
    status_t            fit_status;
  } out_word_t;

  typedef struct packed {
    logic signed [39:0] sum_xx;
    logic signed [39:0] sum_xy;
    logic signed [39:0] sum_yy;
    logic signed [24:0] sum_x;
    logic signed [24:0] sum_y;
    logic signed [39:0] sum_x_dx;
    logic signed [39:0] sum_y_dx;
    logic signed [24:0] sum_dx;
    logic signed [39:0] sum_x_dy;
    logic signed [39:0] sum_y_dy;
    logic signed [24:0] sum_dy;
  } sums_t;

  typedef logic [4:0] addr_t;
  localparam addr_t A_XX  = 5'd0;
  localparam addr_t A_XY  = 5'd1;
  localparam addr_t A_YY  = 5'd2;
  localparam addr_t A_X   = 5'd3;
  localparam addr_t A_Y   = 5'd4;
  localparam addr_t A_N   = 5'd5;
  localparam addr_t A_XDX = 5'd6;
  localparam addr_t A_YDX = 5'd7;
  localparam addr_t A_DX  = 5'd8;
  localparam addr_t A_XDY = 5'd9;
  localparam addr_t A_YDY = 5'd10;
  localparam addr_t A_DY  = 5'd11;
  localparam addr_t A_C00 = 5'd12;
  localparam addr_t A_C01 = 5'd13;
  localparam addr_t A_C02 = 5'd14;
  localparam addr_t A_C11 = 5'd15;
  localparam addr_t A_C12 = 5'd16;
  localparam addr_t A_C22 = 5'd17;
  localparam addr_t A_DET = 5'd18;

  typedef logic [2:0] op_t;
  localparam op_t OP_MUL   = 3'd0;
  localparam op_t OP_MAC   = 3'd1;
  localparam op_t OP_MSB   = 3'd2;
  localparam op_t OP_ZCHK  = 3'd3;
  localparam op_t OP_DIV16 = 3'd4;
  localparam op_t OP_DIV12 = 3'd5;
  localparam op_t OP_END   = 3'd6;

  typedef struct packed {
    op_t   op;
    addr_t a;
    addr_t b;
    addr_t d;
    logic  st;
  } instr_t;

  function automatic instr_t mk(input op_t op, input addr_t a, input addr_t b,
                                input addr_t d, input logic st);
    instr_t r;
    r.op = op;
    r.a  = a;
    r.b  = b;
    r.d  = d;
    r.st = st;
    return r;
  endfunction

  // Solve program: cofactors, determinant and its zero check, then numerator and quotient per coefficient.
  function automatic instr_t alsf_prog(input logic [PcW-1:0] pc);
    instr_t r;
    unique case (pc)
      6'd0:  r = mk(OP_MUL,   A_YY,  A_N,   A_XX,  1'b0);
      6'd1:  r = mk(OP_MSB,   A_Y,   A_Y,   A_C00, 1'b1);
      6'd2:  r = mk(OP_MUL,   A_X,   A_Y,   A_XX,  1'b0);
      6'd3:  r = mk(OP_MSB,   A_XY,  A_N,   A_C01, 1'b1);
      6'd4:  r = mk(OP_MUL,   A_XY,  A_Y,   A_XX,  1'b0);
      6'd5:  r = mk(OP_MSB,   A_YY,  A_X,   A_C02, 1'b1);
      6'd6:  r = mk(OP_MUL,   A_XX,  A_N,   A_XX,  1'b0);
      6'd7:  r = mk(OP_MSB,   A_X,   A_X,   A_C11, 1'b1);
      6'd8:  r = mk(OP_MUL,   A_XY,  A_X,   A_XX,  1'b0);
      6'd9:  r = mk(OP_MSB,   A_XX,  A_Y,   A_C12, 1'b1);
      6'd10: r = mk(OP_MUL,   A_XX,  A_YY,  A_XX,  1'b0);
      6'd11: r = mk(OP_MSB,   A_XY,  A_XY,  A_C22, 1'b1);
      6'd12: r = mk(OP_MUL,   A_XX,  A_C00, A_XX,  1'b0);
      6'd13: r = mk(OP_MAC,   A_XY,  A_C01, A_XX,  1'b0);
      6'd14: r = mk(OP_MAC,   A_X,   A_C02, A_DET, 1'b1);
      6'd15: r = mk(OP_ZCHK,  A_XX,  A_XX,  A_XX,  1'b0);
      6'd16: r = mk(OP_MUL,   A_C00, A_XDX, A_XX,  1'b0);
      6'd17: r = mk(OP_MAC,   A_C01, A_YDX, A_XX,  1'b0);
      6'd18: r = mk(OP_MAC,   A_C02, A_DX,  A_XX,  1'b0);
      6'd19: r = mk(OP_DIV16, A_XX,  A_DET, A_XX,  1'b0);
      6'd20: r = mk(OP_MUL,   A_C01, A_XDX, A_XX,  1'b0);
      6'd21: r = mk(OP_MAC,   A_C11, A_YDX, A_XX,  1'b0);
      6'd22: r = mk(OP_MAC,   A_C12, A_DX,  A_XX,  1'b0);
      6'd23: r = mk(OP_DIV16, A_XX,  A_DET, A_XX,  1'b0);
      6'd24: r = mk(OP_MUL,   A_C02, A_XDX, A_XX,  1'b0);
      6'd25: r = mk(OP_MAC,   A_C12, A_YDX, A_XX,  1'b0);
      6'd26: r = mk(OP_MAC,   A_C22, A_DX,  A_XX,  1'b0);
      6'd27: r = mk(OP_DIV12, A_XX,  A_DET, A_XX,  1'b0);
      6'd28: r = mk(OP_MUL,   A_C00, A_XDY, A_XX,  1'b0);
      6'd29: r = mk(OP_MAC,   A_C01, A_YDY, A_XX,  1'b0);
      6'd30: r = mk(OP_MAC,   A_C02, A_DY,  A_XX,  1'b0);
      6'd31: r = mk(OP_DIV16, A_XX,  A_DET, A_XX,  1'b0);
      6'd32: r = mk(OP_MUL,   A_C01, A_XDY, A_XX,  1'b0);
      6'd33: r = mk(OP_MAC,   A_C11, A_YDY, A_XX,  1'b0);
      6'd34: r = mk(OP_MAC,   A_C12, A_DY,  A_XX,  1'b0);
      6'd35: r = mk(OP_DIV16, A_XX,  A_DET, A_XX,  1'b0);
      6'd36: r = mk(OP_MUL,   A_C02, A_XDY, A_XX,  1'b0);
      6'd37: r = mk(OP_MAC,   A_C12, A_YDY, A_XX,  1'b0);
      6'd38: r = mk(OP_MAC,   A_C22, A_DY,  A_XX,  1'b0);
      6'd39: r = mk(OP_DIV12, A_XX,  A_DET, A_XX,  1'b0);
      default: r = mk(OP_END, A_XX,  A_XX,  A_XX,  1'b0);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### design/alsf_front.sv
`timescale 1ns / 1ps
`default_nettype none
module alsf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  alsf_pkg::in_word_t push_word,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output alsf_pkg::in_word_t head
);
  import alsf_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  in_word_t        q_mem_r [QDepth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW:0]   cnt_r;

  assign full  = (cnt_r == (PtrW + 1)'(QDepth));
  assign empty = (cnt_r == '0);
  assign head  = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (PtrW + 1)'(push) - (PtrW + 1)'(pop);
    end
  end

endmodule
`default_nettype wire

### design/alsf_accum.sv
`timescale 1ns / 1ps
`default_nettype none
module alsf_accum #(
  parameter int unsigned MAX_POINTS = alsf_pkg::MaxPointsDef,
  parameter int unsigned CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  alsf_pkg::in_word_t q_item,
  output logic               q_pop,
  output logic               go,
  input  logic               done,
  output alsf_pkg::sums_t    sums,
  output logic [CNT_W-1:0]   count,
  output logic               ovf
);
  import alsf_pkg::*;

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_RUN  = 2'd1;
  localparam logic [1:0] A_WAIT = 2'd2;
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_POINTS);

  logic [1:0]         st_r;
  logic [2:0]         step_r;
  logic               go_r;
  logic               ovf_r;
  logic [CNT_W-1:0]   count_r;
  in_word_t           item_r;
  logic signed [31:0] mult_r;
  logic signed [15:0] opa;
  logic signed [15:0] opb;
  logic signed [39:0] prod_ext;
  sums_t              s_r;

  assign q_pop    = (st_r == A_IDLE) && !q_empty;
  assign go       = go_r;
  assign sums     = s_r;
  assign count    = count_r;
  assign ovf      = ovf_r;
  assign prod_ext = {{8{mult_r[31]}}, mult_r};

  // One product per cycle on the shared multiplier.
  always_comb begin
    case (step_r)
      3'd0:    begin opa = item_r.src_x; opb = item_r.src_x; end
      3'd1:    begin opa = item_r.src_x; opb = item_r.src_y; end
      3'd2:    begin opa = item_r.src_y; opb = item_r.src_y; end
      3'd3:    begin opa = item_r.src_x; opb = item_r.dst_x; end
      3'd4:    begin opa = item_r.src_y; opb = item_r.dst_x; end
      3'd5:    begin opa = item_r.src_x; opb = item_r.dst_y; end
      3'd6:    begin opa = item_r.src_y; opb = item_r.dst_y; end
      default: begin opa = item_r.src_x; opb = item_r.src_x; end
    endcase
  end

  always_ff @(posedge clk) begin
    mult_r <= opa * opb;
    if (q_pop) begin
      item_r <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= A_IDLE;
      step_r  <= '0;
      go_r    <= 1'b0;
      ovf_r   <= 1'b0;
      count_r <= '0;
      s_r     <= '0;
    end else begin
      go_r <= 1'b0;
      unique case (st_r)
        A_IDLE: begin
          if (!q_empty) begin
            if (count_r == MaxCnt) begin
              ovf_r <= 1'b1;
              if (q_item.last_point) begin
                go_r <= 1'b1;
                st_r <= A_WAIT;
              end
            end else begin
              s_r.sum_x  <= s_r.sum_x  + {{9{q_item.src_x[15]}}, q_item.src_x};
              s_r.sum_y  <= s_r.sum_y  + {{9{q_item.src_y[15]}}, q_item.src_y};
              s_r.sum_dx <= s_r.sum_dx + {{9{q_item.dst_x[15]}}, q_item.dst_x};
              s_r.sum_dy <= s_r.sum_dy + {{9{q_item.dst_y[15]}}, q_item.dst_y};
              count_r    <= count_r + 1'b1;
              step_r     <= '0;
              st_r       <= A_RUN;
            end
          end
        end
        A_RUN: begin
          case (step_r)
            3'd1:    s_r.sum_xx   <= s_r.sum_xx   + prod_ext;
            3'd2:    s_r.sum_xy   <= s_r.sum_xy   + prod_ext;
            3'd3:    s_r.sum_yy   <= s_r.sum_yy   + prod_ext;
            3'd4:    s_r.sum_x_dx <= s_r.sum_x_dx + prod_ext;
            3'd5:    s_r.sum_y_dx <= s_r.sum_y_dx + prod_ext;
            3'd6:    s_r.sum_x_dy <= s_r.sum_x_dy + prod_ext;
            3'd7:    s_r.sum_y_dy <= s_r.sum_y_dy + prod_ext;
            default: ;
          endcase
          step_r <= step_r + 1'b1;
          if (step_r == 3'd7) begin
            if (item_r.last_point) begin
              go_r <= 1'b1;
              st_r <= A_WAIT;
            end else begin
              st_r <= A_IDLE;
            end
          end
        end
        A_WAIT: begin
          if (done) begin
            s_r     <= '0;
            count_r <= '0;
            ovf_r   <= 1'b0;
            st_r    <= A_IDLE;
          end
        end
        default: st_r <= A_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/alsf_solver.sv
`timescale 1ns / 1ps
`default_nettype none
module alsf_solver #(
  parameter int unsigned CNT_W = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic                ovf,
  input  alsf_pkg::sums_t     sums,
  input  logic [CNT_W-1:0]    count,
  output logic                out_valid,
  output alsf_pkg::out_word_t out_word
);
  import alsf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DPREP = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DFIN  = 3'd7;
  localparam int unsigned DcW = $clog2(BigW);

  logic [BigW-1:0] mem [MemDepth];

  logic [2:0]      st_r;
  logic [PcW-1:0]  pc_r;
  addr_t           ld_r;
  logic [BigW-1:0] rd_a_r, rd_b_r;
  logic [BigW-1:0] acc_r, mcand_r, mplier_r, prod_r;
  logic [BigW-1:0] num_r, den_r, rem_r;
  logic [31:0]     q_r;
  logic            hi_r, neg_r;
  logic [DcW-1:0]  dcnt_r;
  logic [2:0]      cidx_r;
  logic [31:0]     coef_r [6];
  logic            out_valid_r;
  out_word_t       res_r;

  instr_t          ins;
  logic [BigW-1:0] load_val, wr_data, n_sh;
  addr_t           wr_addr;
  logic            wr_en, mul_done, ge;
  logic [BigW:0]   rem_sh;
  logic [31:0]     lim, mag;
  out_word_t       fail_word;

  assign ins       = alsf_prog(pc_r);
  assign out_valid = out_valid_r;
  assign out_word  = res_r;
  assign mul_done  = (mplier_r == '0);

  // A failed fit carries zero coefficients; the status depends on where it failed.
  always_comb begin
    fail_word            = '0;
    fail_word.fit_status = (st_r == S_IDLE) ? ST_OVERFLOW : ST_SINGULAR;
  end

  always_comb begin
    unique case (ld_r)
      A_XX:    load_val = {{(BigW-40){sums.sum_xx[39]}},   sums.sum_xx};
      A_XY:    load_val = {{(BigW-40){sums.sum_xy[39]}},   sums.sum_xy};
      A_YY:    load_val = {{(BigW-40){sums.sum_yy[39]}},   sums.sum_yy};
      A_X:     load_val = {{(BigW-25){sums.sum_x[24]}},    sums.sum_x};
      A_Y:     load_val = {{(BigW-25){sums.sum_y[24]}},    sums.sum_y};
      A_N:     load_val = BigW'(count);
      A_XDX:   load_val = {{(BigW-40){sums.sum_x_dx[39]}}, sums.sum_x_dx};
      A_YDX:   load_val = {{(BigW-40){sums.sum_y_dx[39]}}, sums.sum_y_dx};
      A_DX:    load_val = {{(BigW-25){sums.sum_dx[24]}},   sums.sum_dx};
      A_XDY:   load_val = {{(BigW-40){sums.sum_x_dy[39]}}, sums.sum_x_dy};
      A_YDY:   load_val = {{(BigW-40){sums.sum_y_dy[39]}}, sums.sum_y_dy};
      A_DY:    load_val = {{(BigW-25){sums.sum_dy[24]}},   sums.sum_dy};
      default: load_val = '0;
    endcase
  end

  always_comb begin
    wr_en   = (st_r == S_LOAD) || ((st_r == S_MUL) && mul_done && ins.st);
    wr_addr = (st_r == S_LOAD) ? ld_r : ins.d;
    wr_data = (st_r == S_LOAD) ? load_val : prod_r;
  end

  always_comb begin
    n_sh   = (ins.op == OP_DIV16) ? (acc_r << ScaleCoef) : (acc_r << ScaleOfs);
    rem_sh = {rem_r, num_r[BigW-1]};
    ge     = (rem_sh >= {1'b0, den_r});
    lim    = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag    = (hi_r || (q_r > lim)) ? lim : q_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[ins.a];
    rd_b_r <= mem[ins.b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (go) begin
            if (ovf) begin
              res_r       <= fail_word;
              out_valid_r <= 1'b1;
            end else begin
              ld_r <= A_XX;
              st_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          ld_r <= ld_r + 1'b1;
          if (ld_r == A_DY) begin
            pc_r   <= '0;
            cidx_r <= '0;
            acc_r  <= '0;
            st_r   <= S_FETCH;
          end
        end
        S_FETCH: st_r <= S_EXEC;
        S_EXEC: begin
          case (ins.op)
            OP_MUL, OP_MAC, OP_MSB: begin
              mcand_r  <= (ins.op == OP_MSB) ? (BigW'(0) - rd_a_r) : rd_a_r;
              mplier_r <= rd_b_r;
              prod_r   <= (ins.op == OP_MUL) ? '0 : acc_r;
              st_r     <= S_MUL;
            end
            OP_ZCHK: begin
              if (acc_r == '0) begin
                res_r       <= fail_word;
                out_valid_r <= 1'b1;
                st_r        <= S_IDLE;
              end else begin
                pc_r <= pc_r + 1'b1;
                st_r <= S_FETCH;
              end
            end
            OP_DIV16, OP_DIV12: begin
              num_r <= n_sh[BigW-1] ? (BigW'(0) - n_sh) : n_sh;
              den_r <= rd_b_r[BigW-1] ? (BigW'(0) - rd_b_r) : rd_b_r;
              neg_r <= n_sh[BigW-1] ^ rd_b_r[BigW-1];
              st_r  <= S_DPREP;
            end
            default: begin
              res_r.coef_a     <= coef_r[0];
              res_r.coef_b     <= coef_r[1];
              res_r.offset_x   <= coef_r[2];
              res_r.coef_c     <= coef_r[3];
              res_r.coef_d     <= coef_r[4];
              res_r.offset_y   <= coef_r[5];
              res_r.fit_status <= ST_OK;
              out_valid_r      <= 1'b1;
              st_r             <= S_IDLE;
            end
          endcase
        end
        S_MUL: begin
          if (mul_done) begin
            acc_r <= prod_r;
            pc_r  <= pc_r + 1'b1;
            st_r  <= S_FETCH;
          end else begin
            if (mplier_r[0]) begin
              prod_r <= prod_r + mcand_r;
            end
            mcand_r  <= mcand_r << 1;
            mplier_r <= mplier_r >> 1;
          end
        end
        S_DPREP: begin
          // Rounding to nearest, ties away: (2|n| + |d|) / (2|d|).
          num_r  <= (num_r << 1) + den_r;
          den_r  <= den_r << 1;
          rem_r  <= '0;
          q_r    <= '0;
          hi_r   <= 1'b0;
          dcnt_r <= '0;
          st_r   <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= ge ? (rem_sh[BigW-1:0] - den_r) : rem_sh[BigW-1:0];
          num_r  <= num_r << 1;
          q_r    <= {q_r[30:0], ge};
          hi_r   <= hi_r | q_r[31];
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DcW'(BigW - 1)) begin
            st_r <= S_DFIN;
          end
        end
        S_DFIN: begin
          coef_r[cidx_r] <= neg_r ? (32'd0 - mag) : mag;
          cidx_r         <= cidx_r + 1'b1;
          pc_r           <= pc_r + 1'b1;
          st_r           <= S_FETCH;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/affine_least_squares_fit.sv
// Accumulation: the products of each point word run in turn on a shared 16x16 multiplier; a word
// past the limit only sets the overflow flag. Solve on the last word: a load pass of the sums and
// the point count, then a 41-step program run on a bit-serial 128-bit multiply and divide unit.
// A two-word input queue keeps start open while the back end works; busy is high when it is full.
// The result strobe lasts one cycle and cannot be stalled. Synchronous active-low reset
// clears the queue, the sums and the sequencers; no clearing pass follows it.
`timescale 1ns / 1ps
`default_nettype none
module affine_least_squares_fit #(
  parameter int unsigned MAX_POINTS = alsf_pkg::MaxPointsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  alsf_pkg::in_word_t  in_data,
  output logic                out_valid,
  output alsf_pkg::out_word_t out_data
);
  import alsf_pkg::*;

  // Wide enough to hold the point count when it has reached the limit itself.
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  logic             q_empty;
  logic             q_pop;
  in_word_t         q_head;
  logic             solve_go;
  sums_t            sums;
  logic [CNT_W-1:0] count;
  logic             ovf;

  // Front end: queues each accepted word; the last-point flag rides along and
  // tells the back end when to hand the sums to the solver.
  alsf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start && !busy),
    .push_word (in_data),
    .full      (busy),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back end, first half: moment sums, point count and the overflow flag.
  // It waits for the solver's result strobe before it clears for the next set.
  alsf_accum #(
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      (CNT_W)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (q_head),
    .q_pop   (q_pop),
    .go      (solve_go),
    .done    (out_valid),
    .sums    (sums),
    .count   (count),
    .ovf     (ovf)
  );

  // Back end, second half: exact adjugate solve and rounded, saturated quotients.
  alsf_solver #(
    .CNT_W (CNT_W)
  ) u_solver (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (solve_go),
    .ovf       (ovf),
    .sums      (sums),
    .count     (count),
    .out_valid (out_valid),
    .out_word  (out_data)
  );

endmodule
`default_nettype wire

### design/alsf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module alsf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                busy,
  input logic                out_valid,
  input alsf_pkg::out_word_t out_data
);
  import alsf_pkg::*;

  logic status_known;
  logic coefs_zero;

  assign status_known = (out_data.fit_status == ST_OK) ||
                        (out_data.fit_status == ST_SINGULAR) ||
                        (out_data.fit_status == ST_OVERFLOW);
  assign coefs_zero   = (out_data.coef_a == '0) && (out_data.coef_b == '0) &&
                        (out_data.offset_x == '0) && (out_data.coef_c == '0) &&
                        (out_data.coef_d == '0) && (out_data.offset_y == '0);

  `ALSF_ASSERT(a_strobe_single, clk, rst_n, out_valid |=> !out_valid)
  `ALSF_ASSERT(a_status_code, clk, rst_n, out_valid |-> status_known)
  `ALSF_ASSERT(a_fail_zero, clk, rst_n, (out_valid && out_data.fit_status != ST_OK) |-> coefs_zero)
  `ALSF_ASSERT_NR(a_reset_idle, clk, !rst_n |=> (!busy && !out_valid))

endmodule

bind affine_least_squares_fit alsf_checker u_alsf_checker (.*);
`default_nettype wire
